[hw/rtl/small_matrix_arithmetic_engine_assert.svh]
// Assertion macros for the matrix engine checker
`ifndef SMALL_MATRIX_ARITHMETIC_ENGINE_ASSERT_SVH
`define SMALL_MATRIX_ARITHMETIC_ENGINE_ASSERT_SVH

// same-cycle implication
`define SME_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/sme_pkg.sv]
// Package: constants, types and helpers of the matrix engine
`timescale 1ns / 1ps
package sme_pkg;
    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ACC_W     = 64 + $clog2(MAX_DIM) + 1;

    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_ADD    = 3'd3;
    localparam logic [2:0] OP_SUB    = 3'd4;
    localparam logic [2:0] OP_NEG    = 3'd5;
    localparam logic [2:0] OP_SCALE  = 3'd6;

    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_COLS = 2'd2;

    typedef logic [DIM_W-1:0] t_dim;
    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic       data_vld;
        logic       clr;
        logic [2:0] op;
    } t_alu_ctl;

    function automatic t_dim clamp_dim(input logic [3:0] v);
        t_dim r;
        if (v == 4'd0) r = t_dim'(1);
        else if (int'(v) > MAX_DIM) r = t_dim'(MAX_DIM);
        else r = t_dim'(v);
        return r;
    endfunction
endpackage

[hw/rtl/sme_alu.sv]
// Shared multiply/add unit with wide accumulator and saturating finish
`timescale 1ns / 1ps
module sme_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sme_pkg::t_alu_ctl   i_ctl,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    input  logic signed [31:0]  i_val,
    output logic signed [31:0]  o_result,
    output logic                o_overflow
);
    import sme_pkg::*;

    t_acc r_term;
    logic r_term_vld;
    t_acc r_acc;
    t_acc n_term;
    t_acc shifted;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;

    assign mul_b = (i_ctl.op == OP_SCALE) ? i_val : i_b;
    assign prod  = i_a * mul_b;

    always_comb begin
        case (i_ctl.op)
            OP_ADD:  n_term = t_acc'(i_a) + t_acc'(i_b);
            OP_SUB:  n_term = t_acc'(i_a) - t_acc'(i_b);
            OP_NEG:  n_term = -t_acc'(i_a);
            default: n_term = t_acc'(prod);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_vld <= 1'b0;
        end else begin
            r_term_vld <= i_ctl.data_vld;
        end
        if (i_ctl.data_vld) r_term <= n_term;
        if (i_ctl.clr) r_acc <= '0;
        else if (r_term_vld) r_acc <= r_acc + r_term;
    end

    assign shifted = (i_ctl.op == OP_MUL || i_ctl.op == OP_SCALE) ? (r_acc >>> FRAC_BITS) : r_acc;

    always_comb begin
        if (shifted > t_acc'(32'sh7fffffff)) begin
            o_result   = 32'sh7fffffff;
            o_overflow = 1'b1;
        end else if (shifted < -t_acc'(33'sh080000000)) begin
            o_result   = 32'sh80000000;
            o_overflow = 1'b1;
        end else begin
            o_result   = shifted[31:0];
            o_overflow = 1'b0;
        end
    end
endmodule

[hw/rtl/small_matrix_arithmetic_engine.sv]
// Top level of the small matrix arithmetic engine
// A load gives no result. A compute request streams rows x cols result
// elements; each passes through S_CALC once per inner term, inner being a_cols
// for multiply and 1 otherwise, then S_DR1, S_DR2, S_FIN and S_OUT, which waits
// out any output stall. The pace is set by the single multiply-accumulate unit
// and the one read port on each matrix store.
// The stores are not cleared: an element must be loaded before it is used.
`timescale 1ns / 1ps
module small_matrix_arithmetic_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic signed [31:0] i_operand_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_row,
    output logic [2:0]         o_out_col,
    output logic signed [31:0] o_out_value,
    output logic               o_overflow,
    output logic               o_last_element
);
    import sme_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DR1  = 3'd2;
    localparam logic [2:0] S_DR2  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [3:0] r_a_rows, r_a_cols, r_b_cols;
    logic [2:0] r_op;
    logic signed [31:0] r_val;
    t_dim r_rows, r_cols, r_inner;
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic r_rd_vld;
    logic signed [31:0] r_a_q, r_b_q;
    logic signed [31:0] mem_a [DEPTH];
    logic signed [31:0] mem_b [DEPTH];
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic in_acc, issue, is_mul, k_last, j_last, i_last;
    logic r_ovalid, r_ov, r_last;
    logic [2:0] r_row, r_col;
    logic signed [31:0] r_res;
    logic signed [31:0] alu_res;
    logic alu_ov;
    t_alu_ctl alu_ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_mul     = (r_op == OP_MUL);
    assign issue      = (r_state == S_CALC);
    assign k_last     = (t_dim'(r_k) + t_dim'(1) == r_inner);
    assign j_last     = (t_dim'(r_j) + t_dim'(1) == r_cols);
    assign i_last     = (t_dim'(r_i) + t_dim'(1) == r_rows);

    assign rd_addr_a = ADDR_W'(int'(r_i) * MAX_DIM + int'(is_mul ? r_k : r_j));
    assign rd_addr_b = ADDR_W'(int'(is_mul ? r_k : r_i) * MAX_DIM + int'(r_j));
    assign wr_addr   = ADDR_W'(int'(i_row_index) * MAX_DIM + int'(i_col_index));

    always_ff @(posedge i_clk) begin
        if (in_acc && int'(i_row_index) < MAX_DIM && int'(i_col_index) < MAX_DIM) begin
            if (i_operation == OP_LOAD_A) mem_a[wr_addr] <= i_operand_value;
            if (i_operation == OP_LOAD_B) mem_b[wr_addr] <= i_operand_value;
        end
        r_a_q <= mem_a[rd_addr_a];
        r_b_q <= mem_b[rd_addr_b];
    end

    assign alu_ctl.data_vld = r_rd_vld;
    assign alu_ctl.clr      = issue && (r_k == '0);
    assign alu_ctl.op       = r_op;

    sme_alu u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (alu_ctl),
        .i_a        (r_a_q),
        .i_b        (r_b_q),
        .i_val      (r_val),
        .o_result   (alu_res),
        .o_overflow (alu_ov)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_a_rows <= 4'd8;
            r_a_cols <= 4'd8;
            r_b_cols <= 4'd8;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_A_ROWS: r_a_rows <= i_cfg_data;
                    CFG_A_COLS: r_a_cols <= i_cfg_data;
                    CFG_B_COLS: r_b_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_operation >= OP_MUL && i_operation <= OP_SCALE) begin
                        r_op    <= i_operation;
                        r_val   <= i_operand_value;
                        r_rows  <= clamp_dim(r_a_rows);
                        r_cols  <= (i_operation == OP_MUL) ? clamp_dim(r_b_cols)
                                                           : clamp_dim(r_a_cols);
                        r_inner <= (i_operation == OP_MUL) ? clamp_dim(r_a_cols) : t_dim'(1);
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (k_last) r_state <= S_DR1;
                    else r_k <= r_k + 1'b1;
                end
                S_DR1: r_state <= S_DR2;
                S_DR2: r_state <= S_FIN;
                S_FIN: begin
                    r_row    <= 3'(r_i);
                    r_col    <= 3'(r_j);
                    r_res    <= alu_res;
                    r_ov     <= alu_ov;
                    r_last   <= i_last && j_last;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        r_k      <= '0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_CALC;
                            if (j_last) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_row      = r_row;
    assign o_out_col      = r_col;
    assign o_out_value    = r_res;
    assign o_overflow     = r_ov;
    assign o_last_element = r_last;
endmodule

[hw/rtl/sme_checker.sv]
// Port-level checker for the matrix engine, bound to the top level
`timescale 1ns / 1ps
`include "small_matrix_arithmetic_engine_assert.svh"
module sme_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [2:0]         i_operation,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_out_value,
    input logic               o_last_element
);
    import sme_pkg::*;

    logic start_op;
    assign start_op = i_in_valid && !o_in_stall && i_operation >= OP_MUL
                      && i_operation <= OP_SCALE;

    `SME_ASSERT_NOW(busy_while_result, o_out_valid, o_in_stall)
    `SME_ASSERT_NEXT(held_result, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_value))
    `SME_ASSERT_NEXT(compute_goes_busy, start_op, o_in_stall)
    `SME_ASSERT_NEXT(last_ends_stream, o_out_valid && o_last_element && !i_out_stall, !o_out_valid)
endmodule

bind small_matrix_arithmetic_engine sme_port_checker u_sme_checker (.*);
